// ===== sv/gcs_pkg.sv =====
package gcs_pkg;

	typedef logic [31:0] f32_t;

	localparam f32_t F_ONE   = 32'h3F80_0000;
	localparam f32_t F_TWO   = 32'h4000_0000;
	localparam f32_t F_QNAN  = 32'h7FC0_0000;
	localparam f32_t F_INF   = 32'h7F80_0000;
	localparam f32_t MOD_RST = F_ONE;

	// Exponential argument bounds and the small-argument limit (biased exponent).
	localparam logic [30:0] XARG_HI   = 31'h42B2_0000;
	localparam logic [30:0] XARG_LO   = 31'h42D0_0000;
	localparam logic [7:0]  XEXP_TINY = 8'd101;
	localparam logic [7:0]  XEXP_FIX  = 8'd98;

	// Mantissa in 1.44 fixed point with an unbiased binary exponent.
	typedef struct packed {
		logic signed [11:0] ex;
		logic [44:0]        mt;
	} xent_t;

	typedef xent_t [255:0] xtab_t;

	typedef enum logic [2:0] {XK_NORM, XK_NAN, XK_INF, XK_ZERO, XK_ONE} xkind_t;

	typedef struct packed {
		f32_t xx;
		f32_t yy;
		f32_t zz;
		f32_t xy;
		f32_t xz;
		f32_t yz;
		f32_t wx;
		f32_t wy;
		f32_t wz;
	} qprod_t;

	typedef logic [2:0][2:0][31:0] mat3_t;

	function automatic logic [5:0] lzc56(logic [55:0] v);
		logic [5:0] n;
		n = 6'd0;
		for (int i = 0; i < 56; i++) begin
			if (v[i]) n = 6'(55 - i);
		end
		return n;
	endfunction

	// The value is m / 2^55 * 2^(e - 127) with m[55] set; rounds to nearest even.
	function automatic f32_t round_pack(logic s, logic signed [11:0] e, logic [55:0] m);
		logic [11:0] sh;
		logic [55:0] mm;
		logic        lost;
		logic        g;
		logic        st;
		logic [30:0] w;
		lost = 1'b0;
		mm   = m;
		if (e >= 12'sd255) return {s, F_INF[30:0]};
		if (e < 12'sd1) begin
			sh = 12'(12'sd1 - e);
			if (sh >= 12'd56) begin
				mm   = '0;
				lost = |m;
			end else begin
				mm   = m >> sh[5:0];
				lost = |(m & ((56'd1 << sh[5:0]) - 56'd1));
			end
			w = {8'd0, mm[54:32]};
		end else begin
			w = {e[7:0], m[54:32]};
		end
		g  = mm[31];
		st = (|mm[30:0]) | lost;
		w  = w + 31'(g & (st | w[0]));
		return {s, w};
	endfunction

	function automatic f32_t f_mul(f32_t a, f32_t b);
		logic               an;
		logic               ai;
		logic               az;
		logic               bn;
		logic               bi;
		logic               bz;
		logic               s;
		logic [23:0]        ma;
		logic [23:0]        mb;
		logic [47:0]        p;
		logic [5:0]         lz;
		logic signed [11:0] ea;
		logic signed [11:0] eb;
		logic signed [11:0] e;
		an = (&a[30:23]) & (|a[22:0]);
		ai = (&a[30:23]) & ~(|a[22:0]);
		az = ~(|a[30:0]);
		bn = (&b[30:23]) & (|b[22:0]);
		bi = (&b[30:23]) & ~(|b[22:0]);
		bz = ~(|b[30:0]);
		s  = a[31] ^ b[31];
		if (an || bn || (ai && bz) || (az && bi)) return F_QNAN;
		if (ai || bi) return {s, F_INF[30:0]};
		if (az || bz) return {s, 31'd0};
		ma = {|a[30:23], a[22:0]};
		mb = {|b[30:23], b[22:0]};
		ea = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
		eb = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
		p  = ma * mb;
		lz = lzc56({p, 8'd0});
		e  = ea + eb - 12'sd126 - $signed({6'd0, lz});
		return round_pack(s, e, {p, 8'd0} << lz);
	endfunction

	function automatic f32_t f_add(f32_t a, f32_t b);
		logic               an;
		logic               ai;
		logic               bn;
		logic               bi;
		logic               swp;
		logic               sub;
		logic               lost;
		f32_t               x;
		f32_t               y;
		logic [23:0]        mx;
		logic [23:0]        my;
		logic [7:0]         ex;
		logic [7:0]         ey;
		logic [7:0]         d;
		logic [55:0]        aa;
		logic [55:0]        b0;
		logic [55:0]        bb;
		logic [55:0]        sm;
		logic [5:0]         lz;
		logic signed [11:0] e;
		an = (&a[30:23]) & (|a[22:0]);
		ai = (&a[30:23]) & ~(|a[22:0]);
		bn = (&b[30:23]) & (|b[22:0]);
		bi = (&b[30:23]) & ~(|b[22:0]);
		if (an || bn || (ai && bi && (a[31] != b[31]))) return F_QNAN;
		if (ai) return a;
		if (bi) return b;
		swp = b[30:0] > a[30:0];
		x   = swp ? b : a;
		y   = swp ? a : b;
		ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx  = {|x[30:23], x[22:0]};
		my  = {|y[30:23], y[22:0]};
		d   = ex - ey;
		aa  = {1'b0, mx, 31'd0};
		b0  = {1'b0, my, 31'd0};
		if (d >= 8'd56) begin
			bb   = '0;
			lost = |b0;
		end else begin
			bb   = b0 >> d[5:0];
			lost = |(b0 & ((56'd1 << d[5:0]) - 56'd1));
		end
		bb[0] = bb[0] | lost;
		sub   = x[31] ^ y[31];
		sm    = sub ? (aa - bb) : (aa + bb);
		if (sm == '0) return {(~sub) & x[31], 31'd0};
		lz = lzc56(sm);
		e  = $signed({4'd0, ex}) + 12'sd1 - $signed({6'd0, lz});
		return round_pack(x[31], e, sm << lz);
	endfunction

	function automatic f32_t f_sub(f32_t a, f32_t b);
		return f_add(a, {~b[31], b[30:0]});
	endfunction

	function automatic xent_t xent(real v);
		real   r;
		real   f;
		real   rem;
		int    e;
		int    hi;
		int    lo;
		xent_t t;
		r = $exp(v);
		e = 0;
		for (int i = 0; i < 200; i++) begin
			if (r >= 2.0) begin
				r = r * 0.5;
				e = e + 1;
			end
			if (r < 1.0) begin
				r = r * 2.0;
				e = e - 1;
			end
		end
		f    = r - 1.0;
		hi   = $rtoi(f * 4194304.0);
		rem  = f * 4194304.0 - real'(hi);
		lo   = $rtoi(rem * 4194304.0);
		t.ex = 12'(e);
		t.mt = {1'b1, hi[21:0], lo[21:0]};
		return t;
	endfunction

	// Table 0 covers the signed integer part; tables 1 to 3 cover 8-bit fraction chunks.
	function automatic xtab_t mk_tab(int sel);
		xtab_t t;
		real   v;
		for (int j = 0; j < 256; j++) begin
			case (sel)
				0:       v = (j < 128) ? real'(j) : real'(j - 256);
				1:       v = real'(j) * 0.00390625;
				2:       v = real'(j) * 1.52587890625e-05;
				default: v = real'(j) * 5.9604644775390625e-08;
			endcase
			t[j] = xent(v);
		end
		return t;
	endfunction

	localparam xtab_t XT_INT = mk_tab(0);
	localparam xtab_t XT_F1  = mk_tab(1);
	localparam xtab_t XT_F2  = mk_tab(2);
	localparam xtab_t XT_F3  = mk_tab(3);

endpackage

// ===== sv/gaussian_covariance_from_scale_rotation.sv =====
// Channel   Handshake                 Payload
// config    cfg_valid / cfg_ready     cfg_data (scale modifier)
// input     in_valid / in_stall       log_scale_x..z, quat_w..z
// output    out_valid / out_stall     cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz
//
// One splat is accepted per cycle while in_stall is low.
// The pipeline depth is set by the exponential unit: one stage for the scale product, then nine
// stages of argument split, table lookup per chunk, three levels of 45-bit mantissa
// multipliers of two stages each and a rounding stage, then four float stages.
// A held result on the output freezes every stage and raises in_stall for that cycle.
// Reset clears the valid bits and sets the scale modifier to 1.0.
module gaussian_covariance_from_scale_rotation import gcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  f32_t cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  f32_t log_scale_x,
	input  f32_t log_scale_y,
	input  f32_t log_scale_z,
	input  f32_t quat_w,
	input  f32_t quat_x,
	input  f32_t quat_y,
	input  f32_t quat_z,
	output logic out_valid,
	input  logic out_stall,
	output f32_t cov_xx,
	output f32_t cov_xy,
	output f32_t cov_xz,
	output f32_t cov_yy,
	output f32_t cov_yz,
	output f32_t cov_zz
);

	localparam logic [1:0] RA [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] RB [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

	f32_t        mod_q;
	logic [14:1] vld_s;
	logic        en;
	f32_t        sc_s1 [3];
	qprod_t      qp_s1;
	mat3_t       rot_s4;
	mat3_t       rot_s5;
	mat3_t       rot_s6;
	mat3_t       rot_s7;
	mat3_t       rot_s8;
	mat3_t       rot_s9;
	mat3_t       rot_s10;
	f32_t        scl [3];
	mat3_t       l_s11;
	f32_t        pr_s12 [6][3];
	f32_t        ps_s13 [6];
	f32_t        pk_s13 [6];
	f32_t        cov_s14 [6];

	assign cfg_ready = 1'b1;
	assign en        = !(vld_s[14] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_s[14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RST;
			vld_s <= '0;
		end else begin
			if (cfg_valid) mod_q <= cfg_data;
			if (en) vld_s <= {vld_s[13:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s1[0] <= f_mul(mod_q, log_scale_x);
			sc_s1[1] <= f_mul(mod_q, log_scale_y);
			sc_s1[2] <= f_mul(mod_q, log_scale_z);
			qp_s1.xx <= f_mul(quat_x, quat_x);
			qp_s1.yy <= f_mul(quat_y, quat_y);
			qp_s1.zz <= f_mul(quat_z, quat_z);
			qp_s1.xy <= f_mul(quat_x, quat_y);
			qp_s1.xz <= f_mul(quat_x, quat_z);
			qp_s1.yz <= f_mul(quat_y, quat_z);
			qp_s1.wx <= f_mul(quat_w, quat_x);
			qp_s1.wy <= f_mul(quat_w, quat_y);
			qp_s1.wz <= f_mul(quat_w, quat_z);
		end
	end

	gcs_quat u_quat (.clk(clk), .en(en), .q(qp_s1), .r(rot_s4));

	gcs_exp u_exp_x (.clk(clk), .en(en), .x(sc_s1[0]), .y(scl[0]));
	gcs_exp u_exp_y (.clk(clk), .en(en), .x(sc_s1[1]), .y(scl[1]));
	gcs_exp u_exp_z (.clk(clk), .en(en), .x(sc_s1[2]), .y(scl[2]));

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s5  <= rot_s4;
			rot_s6  <= rot_s5;
			rot_s7  <= rot_s6;
			rot_s8  <= rot_s7;
			rot_s9  <= rot_s8;
			rot_s10 <= rot_s9;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					l_s11[i][j] <= f_mul(rot_s10[i][j], scl[j]);
				end
			end
			for (int k = 0; k < 6; k++) begin
				for (int t = 0; t < 3; t++) begin
					pr_s12[k][t] <= f_mul(l_s11[RA[k]][t], l_s11[RB[k]][t]);
				end
				ps_s13[k]  <= f_add(pr_s12[k][0], pr_s12[k][1]);
				pk_s13[k]  <= pr_s12[k][2];
				cov_s14[k] <= f_add(ps_s13[k], pk_s13[k]);
			end
		end
	end

	assign cov_xx = cov_s14[0];
	assign cov_xy = cov_s14[1];
	assign cov_xz = cov_s14[2];
	assign cov_yy = cov_s14[3];
	assign cov_yz = cov_s14[4];
	assign cov_zz = cov_s14[5];

endmodule

// ===== sv/gcs_mmul.sv =====
module gcs_mmul import gcs_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  xent_t a,
	input  xent_t b,
	output xent_t p
);

	logic [45:0]        hh_s1;
	logic [44:0]        hl_s1;
	logic [44:0]        lh_s1;
	logic [43:0]        ll_s1;
	logic signed [11:0] ex_s1;
	logic [89:0]        sum;
	xent_t              p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= a.mt[44:22] * b.mt[44:22];
			hl_s1 <= a.mt[44:22] * b.mt[21:0];
			lh_s1 <= a.mt[21:0] * b.mt[44:22];
			ll_s1 <= a.mt[21:0] * b.mt[21:0];
			ex_s1 <= a.ex + b.ex;
		end
	end

	always_comb begin
		sum = {hh_s1, 44'd0} + (90'(hl_s1) << 22) + (90'(lh_s1) << 22) + 90'(ll_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum[89]) begin
				p_s2.mt <= sum[89:45];
				p_s2.ex <= ex_s1 + 12'sd1;
			end else begin
				p_s2.mt <= sum[88:44];
				p_s2.ex <= ex_s1;
			end
		end
	end

	assign p = p_s2;

endmodule

// ===== sv/gcs_exp.sv =====
module gcs_exp import gcs_pkg::*; (
	input  logic clk,
	input  logic en,
	input  f32_t x,
	output f32_t y
);

	xkind_t              kind_c;
	logic [23:0]         mx;
	logic [5:0]          sh;
	logic [59:0]         mag;
	logic [59:0]         fx_c;
	xkind_t              kind_s [8:1];
	logic [59:0]         fx_s1;
	xent_t               t0_s2;
	xent_t               t1_s2;
	xent_t               t2_s2;
	xent_t               t3_s2;
	xent_t               f4_s [6:2];
	xent_t               pa;
	xent_t               pb;
	xent_t               pc;
	xent_t               pd;
	f32_t                y_s9;

	always_comb begin
		mx   = {1'b1, x[22:0]};
		sh   = 6'(x[30:23] - XEXP_FIX);
		mag  = 60'(mx) << sh;
		fx_c = x[31] ? (60'd0 - mag) : mag;
		if ((&x[30:23]) && (|x[22:0])) begin
			kind_c = XK_NAN;
		end else if (!x[31] && (x[30:0] > XARG_HI)) begin
			kind_c = XK_INF;
		end else if (x[31] && (x[30:0] > XARG_LO)) begin
			kind_c = XK_ZERO;
		end else if (x[30:23] < XEXP_TINY) begin
			kind_c = XK_ONE;
		end else begin
			kind_c = XK_NORM;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s[1] <= kind_c;
			fx_s1     <= fx_c;
			for (int i = 2; i <= 8; i++) kind_s[i] <= kind_s[i-1];
			t0_s2     <= XT_INT[fx_s1[59:52]];
			t1_s2     <= XT_F1[fx_s1[51:44]];
			t2_s2     <= XT_F2[fx_s1[43:36]];
			t3_s2     <= XT_F3[fx_s1[35:28]];
			f4_s[2]   <= '{ex: 12'sd0, mt: {1'b1, 24'd0, fx_s1[27:8]}};
			for (int i = 3; i <= 6; i++) f4_s[i] <= f4_s[i-1];
		end
	end

	gcs_mmul u_ma (.clk(clk), .en(en), .a(t0_s2), .b(t1_s2), .p(pa));
	gcs_mmul u_mb (.clk(clk), .en(en), .a(t2_s2), .b(t3_s2), .p(pb));
	gcs_mmul u_mc (.clk(clk), .en(en), .a(pa), .b(pb), .p(pc));
	gcs_mmul u_md (.clk(clk), .en(en), .a(pc), .b(f4_s[6]), .p(pd));

	always_ff @(posedge clk) begin
		if (en) begin
			case (kind_s[8])
				XK_NORM: y_s9 <= round_pack(1'b0, pd.ex + 12'sd127, {pd.mt, 11'd0});
				XK_NAN:  y_s9 <= F_QNAN;
				XK_INF:  y_s9 <= F_INF;
				XK_ZERO: y_s9 <= '0;
				default: y_s9 <= F_ONE;
			endcase
		end
	end

	assign y = y_s9;

endmodule

// ===== sv/gcs_quat.sv =====
module gcs_quat import gcs_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  qprod_t q,
	output mat3_t  r
);

	mat3_t t_s1;
	mat3_t u_s2;
	mat3_t r_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1[0][0] <= f_add(q.yy, q.zz);
			t_s1[0][1] <= f_sub(q.xy, q.wz);
			t_s1[0][2] <= f_add(q.xz, q.wy);
			t_s1[1][0] <= f_add(q.xy, q.wz);
			t_s1[1][1] <= f_add(q.xx, q.zz);
			t_s1[1][2] <= f_sub(q.yz, q.wx);
			t_s1[2][0] <= f_sub(q.xz, q.wy);
			t_s1[2][1] <= f_add(q.yz, q.wx);
			t_s1[2][2] <= f_add(q.xx, q.yy);
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					u_s2[i][j] <= f_mul(F_TWO, t_s1[i][j]);
					r_s3[i][j] <= (i == j) ? f_sub(F_ONE, u_s2[i][j]) : u_s2[i][j];
				end
			end
		end
	end

	assign r = r_s3;

endmodule

// ===== sv/gcs_checker.sv =====
module gcs_checker import gcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input f32_t cov_xx,
	input f32_t cov_xy,
	input f32_t cov_xz,
	input f32_t cov_yy,
	input f32_t cov_yz,
	input f32_t cov_zz
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cov_xx) && $stable(cov_xy) && $stable(cov_xz)
			&& $stable(cov_yy) && $stable(cov_yz) && $stable(cov_zz))
		else $error("output beat changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output beat");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> !in_stall)
		else $error("input stalled while the output drains");

endmodule

bind gaussian_covariance_from_scale_rotation gcs_checker u_gcs_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import gcs_pkg::*;

	typedef struct {
		f32_t lsx, lsy, lsz, qw, qx, qy, qz;
	} splat_t;

	typedef struct {
		f32_t xx, xy, xz, yy, yz, zz;
	} cov_t;

	typedef struct {
		splat_t sp;
		logic   typed;
		cov_t   cv;
	} row_t;

	typedef enum int {MIX_REAL, MIX_RAW, MIX_SPECIAL} mix_t;

	localparam int HOLD_LEN  = 400;
	localparam int WDOG_MAX  = 20000;
	localparam int DRAIN_CYC = 30;
	localparam int N_PHASE   = 7;
	localparam int N_RAND    = 260;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	f32_t cfg_data;
	logic in_valid;
	logic in_stall;
	f32_t log_scale_x, log_scale_y, log_scale_z;
	f32_t quat_w, quat_x, quat_y, quat_z;
	logic out_valid;
	logic out_stall;
	f32_t cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz;

	gaussian_covariance_from_scale_rotation dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.log_scale_x(log_scale_x), .log_scale_y(log_scale_y), .log_scale_z(log_scale_z),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.cov_xx(cov_xx), .cov_xy(cov_xy), .cov_xz(cov_xz),
		.cov_yy(cov_yy), .cov_yz(cov_yz), .cov_zz(cov_zz)
	);

	cov_t cov_pending[$];
	f32_t modifier;
	int   mismatches;
	int   send_idle_pct;
	int   stall_pct;
	logic hold_req;
	logic hold_on;
	int   quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic real bits_to_real(f32_t b);
		logic [10:0] e;
		logic [51:0] m;
		logic [22:0] f;
		int          ue;
		f  = b[22:0];
		ue = int'(b[30:23]) - 127;
		if (b[30:23] == 8'hFF) begin
			e = 11'h7FF;
			m = {f, 29'd0};
		end else if (b[30:23] == 8'd0) begin
			if (f == 23'd0) return $bitstoreal({b[31], 63'd0});
			ue = -126;
			while (!f[22]) begin
				f  = f << 1;
				ue = ue - 1;
			end
			f  = f << 1;
			ue = ue - 1;
			e  = 11'(ue + 1023);
			m  = {f, 29'd0};
		end else begin
			e = 11'(ue + 1023);
			m = {f, 29'd0};
		end
		return $bitstoreal({b[31], e, m});
	endfunction

	function automatic f32_t real_to_bits(real v);
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic        s;
		int          fe;
		int          sh;
		logic [31:0] r;
		d  = $realtobits(v);
		s  = d[63];
		if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? F_QNAN : {s, F_INF[30:0]};
		if (d[62:52] == 11'd0) return {s, 31'd0};
		fe  = int'(d[62:52]) - 1023 + 127;
		if (fe >= 255) return {s, F_INF[30:0]};
		sig = {11'd0, 1'b1, d[51:0]};
		sh  = (fe >= 1) ? 29 : 29 + 1 - fe;
		if (sh > 60) return {s, 31'd0};
		q    = sig >> sh;
		rem  = sig & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (fe >= 1) r = {s, 8'(fe), q[22:0]};
		else r = {s, 8'd0, q[22:0]};
		if (rem > half || (rem == half && q[0])) r = r + 32'd1;
		return r;
	endfunction

	function automatic f32_t fp_mul(f32_t a, f32_t b);
		return real_to_bits(bits_to_real(a) * bits_to_real(b));
	endfunction

	function automatic f32_t fp_add(f32_t a, f32_t b);
		return real_to_bits(bits_to_real(a) + bits_to_real(b));
	endfunction

	function automatic f32_t fp_sub(f32_t a, f32_t b);
		return real_to_bits(bits_to_real(a) - bits_to_real(b));
	endfunction

	function automatic f32_t fp_exp(f32_t xb);
		real x, t, r, p, e, two_k;
		int  k;
		if (xb[30:23] == 8'hFF && xb[22:0] != 0) return F_QNAN;
		x = bits_to_real(xb);
		if (x > 89.0) return F_INF;
		if (x < -104.0) return 32'd0;
		t = x * 1.4426950408889634;
		k = $rtoi(t >= 0.0 ? t + 0.5 : t - 0.5);
		r = x - real'(k) * 6.93147180369123816490e-01;
		r = r - real'(k) * 1.90821492927058770002e-10;
		p = 1.0;
		for (int n = 13; n >= 1; n--) p = 1.0 + p * r / real'(n);
		two_k = $bitstoreal({1'b0, 11'(k + 1023), 52'd0});
		e = p * two_k;
		if (e > 3.4028234663852886e38) begin
			if (e < 3.4028235677973366e38) return 32'h7F7F_FFFF;
			return F_INF;
		end
		return real_to_bits(e);
	endfunction

	function automatic f32_t dot3(f32_t a0, f32_t a1, f32_t a2, f32_t b0, f32_t b1, f32_t b2);
		return fp_add(fp_add(fp_mul(a0, b0), fp_mul(a1, b1)), fp_mul(a2, b2));
	endfunction

	function automatic cov_t splat_covariance(splat_t sp, f32_t m);
		f32_t sc[3];
		f32_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
		f32_t rm[3][3];
		f32_t lm[3][3];
		cov_t c;
		sc[0] = fp_exp(fp_mul(m, sp.lsx));
		sc[1] = fp_exp(fp_mul(m, sp.lsy));
		sc[2] = fp_exp(fp_mul(m, sp.lsz));
		xx = fp_mul(sp.qx, sp.qx); yy = fp_mul(sp.qy, sp.qy); zz = fp_mul(sp.qz, sp.qz);
		xy = fp_mul(sp.qx, sp.qy); xz = fp_mul(sp.qx, sp.qz); yz = fp_mul(sp.qy, sp.qz);
		wx = fp_mul(sp.qw, sp.qx); wy = fp_mul(sp.qw, sp.qy); wz = fp_mul(sp.qw, sp.qz);
		rm[0][0] = fp_sub(F_ONE, fp_mul(F_TWO, fp_add(yy, zz)));
		rm[0][1] = fp_mul(F_TWO, fp_sub(xy, wz));
		rm[0][2] = fp_mul(F_TWO, fp_add(xz, wy));
		rm[1][0] = fp_mul(F_TWO, fp_add(xy, wz));
		rm[1][1] = fp_sub(F_ONE, fp_mul(F_TWO, fp_add(xx, zz)));
		rm[1][2] = fp_mul(F_TWO, fp_sub(yz, wx));
		rm[2][0] = fp_mul(F_TWO, fp_sub(xz, wy));
		rm[2][1] = fp_mul(F_TWO, fp_add(yz, wx));
		rm[2][2] = fp_sub(F_ONE, fp_mul(F_TWO, fp_add(xx, yy)));
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) lm[i][j] = fp_mul(rm[i][j], sc[j]);
		c.xx = dot3(lm[0][0], lm[0][1], lm[0][2], lm[0][0], lm[0][1], lm[0][2]);
		c.xy = dot3(lm[0][0], lm[0][1], lm[0][2], lm[1][0], lm[1][1], lm[1][2]);
		c.xz = dot3(lm[0][0], lm[0][1], lm[0][2], lm[2][0], lm[2][1], lm[2][2]);
		c.yy = dot3(lm[1][0], lm[1][1], lm[1][2], lm[1][0], lm[1][1], lm[1][2]);
		c.yz = dot3(lm[1][0], lm[1][1], lm[1][2], lm[2][0], lm[2][1], lm[2][2]);
		c.zz = dot3(lm[2][0], lm[2][1], lm[2][2], lm[2][0], lm[2][1], lm[2][2]);
		return c;
	endfunction

	function automatic real unit_rand();
		return real'($urandom) / 4294967296.0;
	endfunction

	function automatic f32_t special_value();
		f32_t vals[10];
		vals = '{32'h0000_0000, 32'h8000_0000, F_INF, 32'hFF80_0000, F_QNAN,
			32'h0000_0001, 32'h7F7F_FFFF, 32'h42B1_7218, 32'hC2D0_0000, F_ONE};
		return vals[$urandom_range(0, 9)];
	endfunction

	function automatic splat_t random_splat();
		splat_t sp;
		mix_t   mix;
		int     pick;
		pick = $urandom_range(0, 9);
		mix  = (pick < 7) ? MIX_REAL : (pick < 9) ? MIX_RAW : MIX_SPECIAL;
		case (mix)
			MIX_REAL: begin
				sp.lsx = real_to_bits(unit_rand() * 13.0 - 10.0);
				sp.lsy = real_to_bits(unit_rand() * 13.0 - 10.0);
				sp.lsz = real_to_bits(unit_rand() * 13.0 - 10.0);
				sp.qw  = real_to_bits(unit_rand() * 2.0 - 1.0);
				sp.qx  = real_to_bits(unit_rand() * 2.0 - 1.0);
				sp.qy  = real_to_bits(unit_rand() * 2.0 - 1.0);
				sp.qz  = real_to_bits(unit_rand() * 2.0 - 1.0);
			end
			MIX_RAW: begin
				sp.lsx = $urandom; sp.lsy = $urandom; sp.lsz = $urandom;
				sp.qw  = $urandom; sp.qx  = $urandom; sp.qy  = $urandom; sp.qz = $urandom;
			end
			default: begin
				sp.lsx = special_value(); sp.lsy = special_value(); sp.lsz = special_value();
				sp.qw  = special_value(); sp.qx  = special_value();
				sp.qy  = special_value(); sp.qz  = special_value();
			end
		endcase
		return sp;
	endfunction

	task automatic send_splat(splat_t sp, logic typed, cov_t cv);
		in_valid    <= 1'b1;
		log_scale_x <= sp.lsx;
		log_scale_y <= sp.lsy;
		log_scale_z <= sp.lsz;
		quat_w      <= sp.qw;
		quat_x      <= sp.qx;
		quat_y      <= sp.qy;
		quat_z      <= sp.qz;
		do @(posedge clk); while (in_stall);
		cov_pending.insert(cov_pending.size(), typed ? cv : splat_covariance(sp, modifier));
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
	endtask

	task automatic write_modifier(f32_t v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		modifier = v;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (cov_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// Long output hold, timed here once the main sequence asks for it.
	initial begin
		hold_on = 1'b0;
		wait (hold_req === 1'b1);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		cov_t exp_c;
		if (out_valid && !out_stall) begin
			if (cov_pending.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result beat got %h %h %h %h %h %h",
						cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz);
			end else begin
				exp_c = cov_pending.pop_front();
				if (exp_c.xx !== cov_xx || exp_c.xy !== cov_xy || exp_c.xz !== cov_xz ||
						exp_c.yy !== cov_yy || exp_c.yz !== cov_yz || exp_c.zz !== cov_zz) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch exp %h %h %h %h %h %h got %h %h %h %h %h %h",
							exp_c.xx, exp_c.xy, exp_c.xz, exp_c.yy, exp_c.yz, exp_c.zz,
							cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("gaussian_covariance_from_scale_rotation verification failed");
			$finish;
		end
	end

	initial begin
		row_t   rows[$];
		splat_t sp;
		cov_t   diag_one;
		cov_t   all_nan;
		cov_t   none;
		f32_t   mods[N_PHASE];
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		log_scale_x   = '0; log_scale_y = '0; log_scale_z = '0;
		quat_w        = '0; quat_x = '0; quat_y = '0; quat_z = '0;
		out_stall     = 1'b0;
		modifier      = MOD_RST;
		mismatches    = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		diag_one = '{F_ONE, 32'd0, 32'd0, F_ONE, 32'd0, F_ONE};
		all_nan  = '{F_QNAN, F_QNAN, F_QNAN, F_QNAN, F_QNAN, F_QNAN};
		none     = '{0, 0, 0, 0, 0, 0};
		// Identity rotation and unit scales, from the reset modifier.
		rows.insert(rows.size(), '{'{0, 0, 0, F_ONE, 0, 0, 0}, 1'b1, diag_one});
		// A zero quaternion still yields the identity matrix.
		rows.insert(rows.size(), '{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, diag_one});
		rows.insert(rows.size(), '{'{F_QNAN, 0, 0, F_ONE, 0, 0, 0}, 1'b1, all_nan});
		rows.insert(rows.size(), '{'{32'hFFFF_FFFF, 0, 0, F_ONE, 0, 0, 0}, 1'b1, all_nan});
		rows.insert(rows.size(), '{'{F_INF, 0, 0, F_ONE, 0, 0, 0}, 1'b0, none});
		rows.insert(rows.size(),
			'{'{32'hFF80_0000, 32'hFF80_0000, 32'hFF80_0000, F_ONE, 0, 0, 0}, 1'b0, none});
		rows.insert(rows.size(),
			'{'{32'h42B1_7218, 32'h42B1_7217, 32'h42B2_0000, F_ONE, 0, 0, 0}, 1'b0, none});
		rows.insert(rows.size(),
			'{'{32'hC2D0_0000, 32'hC2D0_0001, 32'hC2CF_FFFF, F_ONE, 0, 0, 0}, 1'b0, none});
		rows.insert(rows.size(),
			'{'{32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, F_ONE, 0, 0, 0}, 1'b0, none});
		rows.insert(rows.size(), '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, none});
		rows.insert(rows.size(), '{'{32'h3F00_0000, 32'hBF00_0000, 32'h4000_0000,
			32'h3F00_0000, 32'h3F00_0000, 32'h3F00_0000, 32'h3F00_0000}, 1'b0, none});
		rows.insert(rows.size(),
			'{'{0, 0, 0, F_INF, F_QNAN, 32'h7F7F_FFFF, 32'h0000_0001}, 1'b0, none});
		rows.insert(rows.size(), '{'{0, 0, 0, 32'h4120_0000, 32'hC120_0000, 32'h4120_0000,
			32'hC120_0000}, 1'b0, none});
		rows.insert(rows.size(), '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, none});
		rows.insert(rows.size(), '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, none});
		foreach (rows[i]) send_splat(rows[i].sp, rows[i].typed, rows[i].cv);
		drain();

		mods = '{MOD_RST, 32'h3F00_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
			32'h8000_0000, F_ONE};
		for (int ph = 0; ph < N_PHASE; ph++) begin
			if (ph == 4) mods[ph] = real_to_bits(0.2 + unit_rand() * 1.8);
			if (ph > 0) write_modifier(mods[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			for (int n = 0; n < N_RAND; n++) begin
				// Hold the output off while the sender keeps pushing beats.
				if (ph == 1 && n == 20) hold_req = 1'b1;
				sp = random_splat();
				send_splat(sp, 1'b0, none);
			end
			drain();
		end

		if (mismatches == 0 && cov_pending.size() == 0)
			$display("gaussian_covariance_from_scale_rotation verification clean");
		else
			$display("gaussian_covariance_from_scale_rotation verification failed");
		$finish;
	end

endmodule
